### hw/rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants of the bicubic patch evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int GEO_W      = 32;
   localparam int GEO_DEPTH  = 48;
   localparam int GEO_AW     = 6;
   localparam int PAR_W      = 20;
   localparam int OUT_W      = 40;
   localparam int NUM_AXES   = 3;
   localparam int TOL_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TOL_W-1:0] SNAP_TOL_RST = 16'd16;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_BLEND_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SNAP_TOL   = 2'd1;

   localparam logic MODE_HERMITE = 1'b0;
   localparam logic MODE_BEZIER  = 1'b1;

   localparam logic STAT_OK    = 1'b0;
   localparam logic STAT_RANGE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POW,
      ST_WGT,
      ST_PAIR,
      ST_MAC,
      ST_OUT
   } bpe_state_type;

   typedef enum logic [1:0] {
      DST_POW,
      DST_PAIR,
      DST_MAC
   } bpe_dst_type;

   typedef struct packed {
      logic              en;
      logic [GEO_AW-1:0] addr;
      logic [GEO_W-1:0]  data;
   } bpe_wr_type;

endpackage

### hw/rtl/bpe_geom_store.sv
// ----------------------------------------------------------------------------
// bpe_geom_store
// Geometry store: 48 x 32 synchronous memory, one write and one read port,
// registered read. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module bpe_geom_store (
   input  logic                          clock,
   input  logic                          reset,
   input  bpe_pkg::bpe_wr_type           wr,
   input  logic                          rd_en,
   input  logic [bpe_pkg::GEO_AW-1:0]    rd_addr,
   output logic [bpe_pkg::GEO_W-1:0]     rd_data
);

   logic [bpe_pkg::GEO_W-1:0] mem_ff [bpe_pkg::GEO_DEPTH];
   logic [bpe_pkg::GEO_W-1:0] rd_mem_ff;
   logic                      rd_vld_ff;
   logic [bpe_pkg::GEO_DEPTH-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_mem_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_mem_ff : '0;

endmodule

### hw/rtl/bicubic_patch_evaluator_top.sv
// ----------------------------------------------------------------------------
// bicubic_patch_evaluator_top
// Evaluates a bicubic Hermite or Bezier patch point per axis from three 4x4
// geometry matrices held in a synchronous store, using one shared multiplier.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | cmd, axis, row, col, load_value, u/v
//   rsp     | out       | rsp_valid/ready    | coord_x/y/z, status
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// A load request writes the store on accept. An evaluate request holds off new
// requests until its result is loaded; its work is set by the single multiplier
// of 32 x (FRAC_BITS+9) bits (4 powers, 16 pair weights, 48 MACs) and the one read
// port of the geometry store. An out-of-range evaluate goes straight to output.
// Reset clears the store valid bits at once; no clearing pass.
// A finished result waits in the block while the output register is full.
// ----------------------------------------------------------------------------
module bicubic_patch_evaluator_top #(
   parameter int FRAC_BITS = bpe_pkg::FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_cmd,
   input  logic [1:0]                              req_axis,
   input  logic [1:0]                              req_row,
   input  logic [1:0]                              req_col,
   input  logic signed [bpe_pkg::GEO_W-1:0]        req_load_value,
   input  logic signed [bpe_pkg::PAR_W-1:0]        req_u_param,
   input  logic signed [bpe_pkg::PAR_W-1:0]        req_v_param,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [bpe_pkg::OUT_W-1:0]        rsp_coord_x,
   output logic signed [bpe_pkg::OUT_W-1:0]        rsp_coord_y,
   output logic signed [bpe_pkg::OUT_W-1:0]        rsp_coord_z,
   output logic                                    rsp_status,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bpe_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [bpe_pkg::CSR_DATA_W-1:0]          csr_data
);

   localparam int ONE  = 1 << FRAC_BITS;
   localparam int HALF = 1 << (FRAC_BITS - 1);
   localparam int SW   = (FRAC_BITS + 3 > bpe_pkg::PAR_W + 2) ?
                         FRAC_BITS + 3 : bpe_pkg::PAR_W + 2;
   localparam int WW   = FRAC_BITS + 5;
   localparam int BW   = FRAC_BITS + 9;
   localparam int AW   = bpe_pkg::GEO_W;
   localparam int PW   = AW + BW;
   localparam int ACW  = FRAC_BITS + 45;
   localparam int RW   = ACW - FRAC_BITS;
   localparam int OW   = bpe_pkg::OUT_W;
   localparam int POW_END  = 4;
   localparam int PAIR_END = 16;
   localparam int MAC_END  = bpe_pkg::GEO_DEPTH + 2;
   localparam int CW   = $clog2(MAC_END + 1);
   localparam int IW   = bpe_pkg::GEO_AW;

   // state and control
   bpe_pkg::bpe_state_type state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   blend_ff;
   logic [bpe_pkg::TOL_W-1:0] tol_ff;

   // evaluate front end
   logic signed [SW-1:0] su, sv;
   logic                 eval_err;

   // store port
   bpe_pkg::bpe_wr_type  wr;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;
   logic [AW-1:0]        rd_data;
   logic                 rvld_ff;
   logic [IW-1:0]        ridx_ff;

   // shared multiplier
   logic                 mul_go;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   bpe_pkg::bpe_dst_type mul_dst;
   logic [IW-1:0]        mul_idx;
   logic signed [PW-1:0] prod_in, prod_ff, prod_rnd;
   logic                 pvld_ff;
   bpe_pkg::bpe_dst_type pdst_ff;
   logic [IW-1:0]        pidx_ff;

   // working values
   logic [FRAC_BITS:0]   par_ff [2];
   logic [FRAC_BITS:0]   t2_ff  [2];
   logic [FRAC_BITS:0]   t3_ff  [2];
   logic signed [WW-1:0] wu_ff  [4];
   logic signed [WW-1:0] wv_ff  [4];
   logic signed [BW-1:0] wuv_ff [16];
   logic signed [ACW-1:0] acc_ff, acc_in, fin_sum_ff, fin_rnd;
   logic                 fin_vld_ff;
   logic [1:0]           fin_axis_ff;
   logic signed [OW-1:0] res_ff [bpe_pkg::NUM_AXES];
   logic signed [OW-1:0] fin_sat;
   logic                 status_ff;

   // output register
   logic                 out_load;
   logic                 rsp_valid_ff;
   logic signed [OW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                 rsp_status_ff;

   function automatic logic signed [SW-1:0] snap_fn(input logic signed [SW-1:0] t,
                                                    input logic [bpe_pkg::TOL_W-1:0] tol);
      logic signed [SW-1:0] d0;
      logic signed [SW-1:0] d1;
      logic signed [SW-1:0] tl;
      d0 = (t < 0) ? -t : t;
      d1 = t - SW'(ONE);
      d1 = (d1 < 0) ? -d1 : d1;
      tl = SW'(tol);
      if (d0 < tl) begin
         snap_fn = '0;
      end else if (d1 < tl) begin
         snap_fn = SW'(ONE);
      end else begin
         snap_fn = t;
      end
   endfunction

   function automatic logic signed [WW-1:0] wgt_fn(input logic mode, input logic [1:0] k,
                                                   input logic [FRAC_BITS:0] t,
                                                   input logic [FRAC_BITS:0] t2,
                                                   input logic [FRAC_BITS:0] t3);
      logic signed [WW-1:0] a, a2, a3, b, b2, b3, c, c3, o;
      a  = WW'(t3);
      b  = WW'(t2);
      c  = WW'(t);
      o  = WW'(ONE);
      a2 = a <<< 1;
      a3 = a2 + a;
      b2 = b <<< 1;
      b3 = b2 + b;
      c3 = (c <<< 1) + c;
      if (mode == bpe_pkg::MODE_BEZIER) begin
         case (k)
            2'd0:    wgt_fn = o - a + b3 - c3;
            2'd1:    wgt_fn = a3 - (b3 <<< 1) + c3;
            2'd2:    wgt_fn = b3 - a3;
            default: wgt_fn = a;
         endcase
      end else begin
         case (k)
            2'd0:    wgt_fn = a2 - b3 + o;
            2'd1:    wgt_fn = b3 - a2;
            2'd2:    wgt_fn = a - b2 + c;
            default: wgt_fn = a - b;
         endcase
      end
   endfunction

   bpe_geom_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign su       = snap_fn(SW'(req_u_param), tol_ff);
   assign sv       = snap_fn(SW'(req_v_param), tol_ff);
   assign eval_err = (su < 0) || (su > SW'(ONE)) || (sv < 0) || (sv > SW'(ONE));

   assign prod_in  = mul_a * mul_b;
   assign prod_rnd = prod_ff + PW'(HALF);

   assign acc_in   = (pidx_ff[3:0] == 4'd0) ? ACW'(prod_ff) : acc_ff + ACW'(prod_ff);
   assign fin_rnd  = fin_sum_ff + ACW'(HALF);

   always_comb begin
      logic signed [RW-1:0] r;
      r = fin_rnd[ACW-1:FRAC_BITS];
      if ((&r[RW-1:OW-1]) || !(|r[RW-1:OW-1])) begin
         fin_sat = r[OW-1:0];
      end else if (r[RW-1]) begin
         fin_sat = {1'b1, {(OW-1){1'b0}}};
      end else begin
         fin_sat = {1'b0, {(OW-1){1'b1}}};
      end
   end

   // next state and issue control
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      wr       = '0;
      rd_en    = 1'b0;
      rd_addr  = cnt_ff[IW-1:0];
      mul_go   = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      mul_dst  = bpe_pkg::DST_POW;
      mul_idx  = cnt_ff[IW-1:0];
      out_load = 1'b0;
      case (state_ff)
         bpe_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == bpe_pkg::CMD_LOAD) begin
                  wr.en   = (req_axis < 2'(bpe_pkg::NUM_AXES));
                  wr.addr = {req_axis, req_row, req_col};
                  wr.data = req_load_value;
               end else begin
                  state_in = eval_err ? bpe_pkg::ST_OUT : bpe_pkg::ST_POW;
                  cnt_in   = '0;
               end
            end
         end
         bpe_pkg::ST_POW: begin
            // t*t for u and v, then t2*t for u and v
            if (cnt_ff < CW'(POW_END)) begin
               mul_go = 1'b1;
               mul_a  = cnt_ff[1] ? AW'(t2_ff[cnt_ff[0]]) : AW'(par_ff[cnt_ff[0]]);
               mul_b  = BW'(par_ff[cnt_ff[0]]);
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = bpe_pkg::ST_WGT;
               cnt_in   = '0;
            end
         end
         bpe_pkg::ST_WGT: begin
            state_in = bpe_pkg::ST_PAIR;
         end
         bpe_pkg::ST_PAIR: begin
            if (cnt_ff < CW'(PAIR_END)) begin
               mul_go  = 1'b1;
               mul_dst = bpe_pkg::DST_PAIR;
               mul_a   = AW'(wu_ff[cnt_ff[3:2]]);
               mul_b   = BW'(wv_ff[cnt_ff[1:0]]);
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               state_in = bpe_pkg::ST_MAC;
               cnt_in   = '0;
            end
         end
         bpe_pkg::ST_MAC: begin
            rd_en   = (cnt_ff < CW'(bpe_pkg::GEO_DEPTH));
            mul_go  = rvld_ff;
            mul_dst = bpe_pkg::DST_MAC;
            mul_a   = rd_data;
            mul_b   = wuv_ff[ridx_ff[3:0]];
            mul_idx = ridx_ff;
            if (cnt_ff < CW'(MAC_END)) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = bpe_pkg::ST_OUT;
               cnt_in   = '0;
            end
         end
         bpe_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = bpe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpe_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpe_pkg::ST_IDLE;
         cnt_ff       <= '0;
         blend_ff     <= bpe_pkg::MODE_HERMITE;
         tol_ff       <= bpe_pkg::SNAP_TOL_RST;
         pvld_ff      <= 1'b0;
         rvld_ff      <= 1'b0;
         fin_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pvld_ff    <= mul_go;
         rvld_ff    <= rd_en;
         fin_vld_ff <= pvld_ff && (pdst_ff == bpe_pkg::DST_MAC) && (pidx_ff[3:0] == 4'hF);
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bpe_pkg::REG_BLEND_MODE: blend_ff <= csr_data[0];
               bpe_pkg::REG_SNAP_TOL:   tol_ff   <= csr_data[bpe_pkg::TOL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == bpe_pkg::ST_IDLE && req_valid && req_cmd == bpe_pkg::CMD_EVAL) begin
         par_ff[0] <= su[FRAC_BITS:0];
         par_ff[1] <= sv[FRAC_BITS:0];
         if (eval_err) begin
            status_ff <= bpe_pkg::STAT_RANGE;
            for (int i = 0; i < bpe_pkg::NUM_AXES; i++) begin
               res_ff[i] <= '0;
            end
         end else begin
            status_ff <= bpe_pkg::STAT_OK;
         end
      end

      prod_ff <= prod_in;
      pdst_ff <= mul_dst;
      pidx_ff <= mul_idx;
      ridx_ff <= cnt_ff[IW-1:0];

      if (pvld_ff) begin
         case (pdst_ff)
            bpe_pkg::DST_POW: begin
               if (pidx_ff[1]) begin
                  t3_ff[pidx_ff[0]] <= prod_rnd[2*FRAC_BITS:FRAC_BITS];
               end else begin
                  t2_ff[pidx_ff[0]] <= prod_rnd[2*FRAC_BITS:FRAC_BITS];
               end
            end
            bpe_pkg::DST_PAIR: wuv_ff[pidx_ff[3:0]] <= prod_rnd[FRAC_BITS+BW-1:FRAC_BITS];
            bpe_pkg::DST_MAC:  acc_ff <= acc_in;
            default: ;
         endcase
      end

      fin_sum_ff  <= acc_in;
      fin_axis_ff <= pidx_ff[IW-1:4];
      if (fin_vld_ff) begin
         res_ff[fin_axis_ff] <= fin_sat;
      end

      if (state_ff == bpe_pkg::ST_WGT) begin
         for (int k = 0; k < 4; k++) begin
            wu_ff[k] <= wgt_fn(blend_ff, 2'(k), par_ff[0], t2_ff[0], t3_ff[0]);
            wv_ff[k] <= wgt_fn(blend_ff, 2'(k), par_ff[1], t2_ff[1], t3_ff[1]);
         end
      end

      if (out_load) begin
         rsp_x_ff      <= res_ff[0];
         rsp_y_ff      <= res_ff[1];
         rsp_z_ff      <= res_ff[2];
         rsp_status_ff <= status_ff;
      end
   end

   assign req_ready   = (state_ff == bpe_pkg::ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_coord_x = rsp_x_ff;
   assign rsp_coord_y = rsp_y_ff;
   assign rsp_coord_z = rsp_z_ff;
   assign rsp_status  = rsp_status_ff;

   // checks
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == bpe_pkg::STAT_RANGE |->
         rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_z_ff == '0)
      else $error("range error request with nonzero coordinates");

   a_prod_busy: assert property (@(posedge clock) disable iff (reset)
      pvld_ff |-> state_ff == bpe_pkg::ST_POW || state_ff == bpe_pkg::ST_PAIR ||
                  state_ff == bpe_pkg::ST_MAC)
      else $error("product valid outside a compute phase");

   a_read_mac: assert property (@(posedge clock) disable iff (reset)
      rvld_ff |-> state_ff == bpe_pkg::ST_MAC)
      else $error("store read data outside MAC phase");

   a_fin_mac: assert property (@(posedge clock) disable iff (reset)
      fin_vld_ff |-> state_ff == bpe_pkg::ST_MAC)
      else $error("axis sum finished outside MAC phase");

   a_eval_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == bpe_pkg::CMD_EVAL |=>
         state_ff != bpe_pkg::ST_IDLE)
      else $error("evaluate request did not start work");

endmodule
